/* sv/tts_pkg.sv */
// Shared types and constants of the triangle to trapezoid splitter.
// No dependencies; every other file of the block refers to this package by scoped names.
package tts_pkg;

	localparam int COORD_BITS  = 32;
	localparam int DIFF_BITS   = COORD_BITS + 1;
	localparam int LO_BITS     = COORD_BITS / 2;
	localparam int HI_BITS     = COORD_BITS - LO_BITS;
	localparam int PPL_BITS    = DIFF_BITS + LO_BITS + 1;
	localparam int PPH_BITS    = DIFF_BITS + HI_BITS + 1;
	localparam int PROD_BITS   = DIFF_BITS + COORD_BITS + 1;

	// Queue depth must stay a power of two: pointers wrap on their own.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic        [COORD_BITS-1:0] span_t;
	typedef logic        [1:0]            vidx_t;

	typedef struct packed {
		vidx_t l_from;
		vidx_t l_to;
		vidx_t r_from;
		vidx_t r_to;
	} edges_t;

	typedef struct packed {
		logic   split;
		edges_t flat_edges;
		vidx_t  ia;
		vidx_t  ib;
		vidx_t  ic;
		coord_t top_y;
		coord_t mid_y;
		coord_t bot_y;
	} meta_t;

	typedef struct packed {
		meta_t  meta;
		coord_t xa;
		coord_t xb;
		coord_t xc;
	} job_t;

	typedef struct packed {
		coord_t top_y;
		coord_t bottom_y;
		vidx_t  left_from;
		vidx_t  left_to;
		vidx_t  right_from;
		vidx_t  right_to;
		logic   last_piece;
	} trap_t;

endpackage

/* sv/tts_channels.sv */
// Valid/ready channel interfaces: triangles in, trapezoids out.
// Depends on tts_pkg for the coordinate and index types.
interface tts_tri_if;
	logic            valid;
	logic            ready;
	tts_pkg::coord_t x_first;
	tts_pkg::coord_t y_first;
	tts_pkg::coord_t x_second;
	tts_pkg::coord_t y_second;
	tts_pkg::coord_t x_third;
	tts_pkg::coord_t y_third;

	modport source (output valid, x_first, y_first, x_second, y_second, x_third, y_third,
		input ready);
	modport sink (input valid, x_first, y_first, x_second, y_second, x_third, y_third,
		output ready);
endinterface

interface tts_trap_if;
	logic            valid;
	logic            ready;
	tts_pkg::coord_t top_y;
	tts_pkg::coord_t bottom_y;
	tts_pkg::vidx_t  left_from;
	tts_pkg::vidx_t  left_to;
	tts_pkg::vidx_t  right_from;
	tts_pkg::vidx_t  right_to;
	logic            last_piece;

	modport source (output valid, top_y, bottom_y, left_from, left_to, right_from, right_to,
		last_piece, input ready);
	modport sink (input valid, top_y, bottom_y, left_from, left_to, right_from, right_to,
		last_piece, output ready);
endinterface

/* sv/tts_front.sv */
// Front end: sorts the three vertices by y, rejects degenerate triangles, classifies the rest.
// Depends on tts_pkg and tts_tri_if; feeds tts_queue.
module tts_front (
	tts_tri_if.sink        triangle,
	input  logic           q_ready,
	output logic           push_valid,
	output tts_pkg::job_t  push_job
);

	tts_pkg::coord_t vx [3];
	tts_pkg::coord_t vy [3];
	logic [2:0][2:0] ygt;
	logic [2:0][2:0] xgt;
	tts_pkg::vidx_t  a, b, c;
	logic            all_y_eq, all_x_eq, flat_top, flat_bot;
	tts_pkg::edges_t flat_edges;

	assign vx[0] = triangle.x_first;
	assign vy[0] = triangle.y_first;
	assign vx[1] = triangle.x_second;
	assign vy[1] = triangle.y_second;
	assign vx[2] = triangle.x_third;
	assign vy[2] = triangle.y_third;

	// All pairwise compares in parallel; the sort network then only steers indices.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				ygt[i][j] = vy[i] > vy[j];
				xgt[i][j] = vx[i] > vx[j];
			end
		end
	end

	assign all_y_eq = !ygt[0][1] && !ygt[1][0] && !ygt[0][2] && !ygt[2][0];
	assign all_x_eq = !xgt[0][1] && !xgt[1][0] && !xgt[0][2] && !xgt[2][0];

	always_comb begin
		a = tts_pkg::vidx_t'(0);
		b = tts_pkg::vidx_t'(1);
		c = tts_pkg::vidx_t'(2);
		// stable compare-and-swap, strictly greater only
		if (ygt[a][b]) begin
			{a, b} = {b, a};
		end
		if (ygt[a][c]) begin
			{a, c} = {c, a};
		end
		if (ygt[b][c]) begin
			{b, c} = {c, b};
		end
		flat_top = !ygt[b][a];
		flat_bot = !flat_top && !ygt[c][b];
		flat_edges = '0;
		// zero height cannot follow a flat edge once the all-equal case is gone
		if (flat_top) begin
			if (xgt[a][b]) begin
				{a, b} = {b, a};
			end
			flat_edges = '{l_from: a, l_to: c, r_from: b, r_to: c};
		end else if (flat_bot) begin
			if (xgt[b][c]) begin
				{b, c} = {c, b};
			end
			flat_edges = '{l_from: a, l_to: b, r_from: a, r_to: c};
		end
	end

	assign triangle.ready = q_ready;
	assign push_valid     = triangle.valid && !all_y_eq && !all_x_eq;

	always_comb begin
		push_job.meta.split      = !flat_top && !flat_bot;
		push_job.meta.flat_edges = flat_edges;
		push_job.meta.ia         = a;
		push_job.meta.ib         = b;
		push_job.meta.ic         = c;
		push_job.meta.top_y      = vy[a];
		push_job.meta.mid_y      = vy[b];
		push_job.meta.bot_y      = vy[c];
		push_job.xa              = vx[a];
		push_job.xb              = vx[b];
		push_job.xc              = vx[c];
	end

endmodule

/* sv/tts_queue.sv */
// Short job queue between the front end and the back end.
// Depends on tts_pkg for the job type and depth.
module tts_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tts_pkg::job_t push_job,
	output logic          ready,
	output logic          valid,
	output tts_pkg::job_t head,
	input  logic          pop
);

	tts_pkg::job_t                     mem_q [tts_pkg::QUEUE_DEPTH];
	logic [tts_pkg::QPTR_BITS-1:0]     rd_q, wr_q;
	logic [tts_pkg::QCNT_BITS-1:0]     cnt_q;
	logic                              do_push, do_pop;

	assign ready   = cnt_q != tts_pkg::QCNT_BITS'(tts_pkg::QUEUE_DEPTH);
	assign valid   = cnt_q != '0;
	assign head    = mem_q[rd_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + tts_pkg::QPTR_BITS'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + tts_pkg::QPTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + tts_pkg::QCNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - tts_pkg::QCNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

/* sv/tts_back.sv */
// Back end: side test of the middle vertex through split cross products, then trapezoid output.
// Depends on tts_pkg and tts_trap_if; drains tts_queue.
module tts_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  tts_pkg::job_t q_job,
	output logic          q_pop,
	tts_trap_if.source    trapezoid
);

	localparam int LO = tts_pkg::LO_BITS;
	localparam int CB = tts_pkg::COORD_BITS;
	localparam int PL = tts_pkg::PPL_BITS;
	localparam int PH = tts_pkg::PPH_BITS;
	localparam int PB = tts_pkg::PROD_BITS;

	tts_pkg::meta_t        meta_s1, meta_s2, meta_s3;
	tts_pkg::diff_t        dxab_s1, dxac_s1;
	tts_pkg::span_t        dyab_s1, dyac_s1;
	logic signed [PL-1:0]  pl_ab_s2, pl_ac_s2;
	logic signed [PH-1:0]  ph_ab_s2, ph_ac_s2;
	logic signed [PB-1:0]  p_s3, q_s3;
	logic                  v_s1, v_s2, v_s3;
	logic                  phase_q, out_valid_q;
	tts_pkg::trap_t        out_q, trap_d;
	logic                  out_load, emit, release3, adv1, adv2, adv3, left;

	// stage control: a stage moves on when the one after it is empty or moving
	assign out_load = !out_valid_q || trapezoid.ready;
	assign emit     = v_s3 && out_load;
	assign release3 = emit && (!meta_s3.split || phase_q);
	assign adv3     = !v_s3 || release3;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign q_pop    = adv1;

	// middle vertex on the left when (b.x-a.x)*(c.y-a.y) <= (c.x-a.x)*(b.y-a.y)
	assign left = p_s3 <= q_s3;

	always_comb begin
		trap_d.top_y      = meta_s3.top_y;
		trap_d.bottom_y   = meta_s3.bot_y;
		trap_d.last_piece = 1'b1;
		{trap_d.left_from, trap_d.left_to, trap_d.right_from, trap_d.right_to} =
			meta_s3.flat_edges;
		if (meta_s3.split && !phase_q) begin
			trap_d.bottom_y   = meta_s3.mid_y;
			trap_d.last_piece = 1'b0;
			if (left) begin
				{trap_d.left_from, trap_d.left_to, trap_d.right_from, trap_d.right_to} =
					{meta_s3.ia, meta_s3.ib, meta_s3.ia, meta_s3.ic};
			end else begin
				{trap_d.left_from, trap_d.left_to, trap_d.right_from, trap_d.right_to} =
					{meta_s3.ia, meta_s3.ic, meta_s3.ia, meta_s3.ib};
			end
		end else if (meta_s3.split) begin
			trap_d.top_y = meta_s3.mid_y;
			if (left) begin
				{trap_d.left_from, trap_d.left_to, trap_d.right_from, trap_d.right_to} =
					{meta_s3.ib, meta_s3.ic, meta_s3.ia, meta_s3.ic};
			end else begin
				{trap_d.left_from, trap_d.left_to, trap_d.right_from, trap_d.right_to} =
					{meta_s3.ia, meta_s3.ic, meta_s3.ib, meta_s3.ic};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= q_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (emit) begin
				phase_q <= meta_s3.split && !phase_q;
			end
			if (out_load) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && q_valid) begin
			meta_s1 <= q_job.meta;
			dxab_s1 <= tts_pkg::diff_t'(q_job.xb) - tts_pkg::diff_t'(q_job.xa);
			dxac_s1 <= tts_pkg::diff_t'(q_job.xc) - tts_pkg::diff_t'(q_job.xa);
			dyab_s1 <= tts_pkg::span_t'(q_job.meta.mid_y - q_job.meta.top_y);
			dyac_s1 <= tts_pkg::span_t'(q_job.meta.bot_y - q_job.meta.top_y);
		end
		if (adv2 && v_s1) begin
			meta_s2  <= meta_s1;
			pl_ab_s2 <= PL'(dxab_s1) * PL'($signed({1'b0, dyac_s1[LO-1:0]}));
			ph_ab_s2 <= PH'(dxab_s1) * PH'($signed({1'b0, dyac_s1[CB-1:LO]}));
			pl_ac_s2 <= PL'(dxac_s1) * PL'($signed({1'b0, dyab_s1[LO-1:0]}));
			ph_ac_s2 <= PH'(dxac_s1) * PH'($signed({1'b0, dyab_s1[CB-1:LO]}));
		end
		if (adv3 && v_s2) begin
			meta_s3 <= meta_s2;
			p_s3    <= (PB'(ph_ab_s2) <<< LO) + PB'(pl_ab_s2);
			q_s3    <= (PB'(ph_ac_s2) <<< LO) + PB'(pl_ac_s2);
		end
		if (emit) begin
			out_q <= trap_d;
		end
	end

	assign trapezoid.valid      = out_valid_q;
	assign trapezoid.top_y      = out_q.top_y;
	assign trapezoid.bottom_y   = out_q.bottom_y;
	assign trapezoid.left_from  = out_q.left_from;
	assign trapezoid.left_to    = out_q.left_to;
	assign trapezoid.right_from = out_q.right_from;
	assign trapezoid.right_to   = out_q.right_to;
	assign trapezoid.last_piece = out_q.last_piece;

endmodule

/* sv/triangle_trapezoid_split.sv */
// Top level of the triangle to trapezoid splitter: front end, job queue, back end.
// Depends on tts_pkg, tts_channels, tts_front, tts_queue and tts_back.
//
//   channel     role  handshake      payload
//   triangle    sink  valid/ready    x/y of three vertices, signed 16.16
//   trapezoid   src   valid/ready    top_y, bottom_y, left/right edge indices, last_piece
//
// A triangle is accepted in any cycle the queue has room; its classification goes straight
// into the queue. Three back-end stages (differences, partial products, product sums) follow,
// and then the output register.
// The output register issues one trapezoid a cycle when not stalled: two for a split triangle,
// one for a flat one, none for a rejected one. Output stalls back up through the stages into
// the queue and only then hold off the input. Reset clears valid flags and queue pointers, not payload.
module triangle_trapezoid_split (
	input  logic        clk,
	input  logic        arst_n,
	tts_tri_if.sink     triangle,
	tts_trap_if.source  trapezoid
);

	// front end to queue
	logic          push_valid;
	tts_pkg::job_t push_job;
	logic          q_ready;

	// queue to back end
	logic          q_valid;
	tts_pkg::job_t q_job;
	logic          q_pop;

	// sort, reject and classify in the acceptance cycle
	tts_front u_front (
		.triangle   (triangle),
		.q_ready    (q_ready),
		.push_valid (push_valid),
		.push_job   (push_job)
	);

	// decouple acceptance from trapezoid output so either side can stall
	tts_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid),
		.push_job (push_job),
		.ready    (q_ready),
		.valid    (q_valid),
		.head     (q_job),
		.pop      (q_pop)
	);

	// side test and trapezoid issue
	tts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (q_job),
		.q_pop     (q_pop),
		.trapezoid (trapezoid)
	);

`ifndef SYNTHESIS
	// the second trapezoid of a split triangle follows its first without a gap
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(trapezoid.valid && trapezoid.ready && !trapezoid.last_piece) |=> trapezoid.valid)
		else $error("second trapezoid of a split triangle missing");

	// every trapezoid spans a positive height
	a_height: assert property (@(posedge clk) disable iff (!arst_n)
		trapezoid.valid |-> (trapezoid.top_y < trapezoid.bottom_y))
		else $error("trapezoid with non-positive height");

	// an edge always joins two distinct vertices
	a_edges: assert property (@(posedge clk) disable iff (!arst_n)
		trapezoid.valid |->
			(trapezoid.left_from != trapezoid.left_to &&
			 trapezoid.right_from != trapezoid.right_to))
		else $error("trapezoid edge starts and ends at the same vertex");
`endif

endmodule

/* test/testbench.sv */
// Self-checking testbench for triangle_trapezoid_split: triangles in, trapezoids out.
// Depends on tts_pkg and the tts_tri_if / tts_trap_if channels of the block.
// Predicts each trapezoid in the testbench and checks the output stream in order.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Depth from triangle acceptance to the output register load.
	localparam int PIPE_LATENCY = 4;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int REPORT_LIMIT = 10;
	localparam int PARK_CYCLES  = 300;

	localparam tts_pkg::coord_t COORD_MIN = {1'b1, {(tts_pkg::COORD_BITS-1){1'b0}}};
	localparam tts_pkg::coord_t COORD_MAX = {1'b0, {(tts_pkg::COORD_BITS-1){1'b1}}};

	logic clk;
	logic arst_n;

	tts_tri_if  triangle_ch ();
	tts_trap_if trapezoid_ch ();

	triangle_trapezoid_split DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.triangle  (triangle_ch),
		.trapezoid (trapezoid_ch)
	);

	// Trapezoids still owed by the block, oldest first.
	tts_pkg::trap_t trapezoids_due[$];

	int  mismatches     = 0;
	int  traps_checked  = 0;
	int  triangles_sent = 0;
	int  split_count    = 0;
	int  flat_count     = 0;
	int  reject_count   = 0;
	int  cycle_count    = 0;
	int  park_request   = 0;
	bit  src_steady     = 0;
	bit  sink_steady    = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d trapezoids outstanding", cycle_count,
				trapezoids_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic tts_pkg::coord_t fx(input int whole);
		return tts_pkg::coord_t'(whole * 65536);
	endfunction

	// Gap length: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic tts_pkg::trap_t make_trap(input tts_pkg::coord_t top,
		input tts_pkg::coord_t bot, input tts_pkg::vidx_t lf, input tts_pkg::vidx_t lt,
		input tts_pkg::vidx_t rf, input tts_pkg::vidx_t rt, input logic last);
		tts_pkg::trap_t t;
		t.top_y      = top;
		t.bottom_y   = bot;
		t.left_from  = lf;
		t.left_to    = lt;
		t.right_from = rf;
		t.right_to   = rt;
		t.last_piece = last;
		return t;
	endfunction

	function automatic string trap_text(input tts_pkg::trap_t t);
		return $sformatf("y %0d..%0d left %0d->%0d right %0d->%0d last %0d",
			$signed(t.top_y), $signed(t.bottom_y), t.left_from, t.left_to,
			t.right_from, t.right_to, t.last_piece);
	endfunction

	// Sort the vertices by y, classify the triangle and queue the trapezoids it yields.
	function automatic void predict_trapezoids(input tts_pkg::coord_t x0,
		input tts_pkg::coord_t y0, input tts_pkg::coord_t x1, input tts_pkg::coord_t y1,
		input tts_pkg::coord_t x2, input tts_pkg::coord_t y2);
		tts_pkg::coord_t vx[3];
		tts_pkg::coord_t vy[3];
		tts_pkg::vidx_t  a, b, c, t;
		tts_pkg::diff_t  dxab, dyab, dxac, dyac;
		logic signed [2*tts_pkg::DIFF_BITS-1:0] cross_ab, cross_ac;
		vx[0] = x0; vy[0] = y0;
		vx[1] = x1; vy[1] = y1;
		vx[2] = x2; vy[2] = y2;
		a = 2'd0; b = 2'd1; c = 2'd2;

		// Stable compare-and-swap: swap only on strictly greater y.
		if (vy[a] > vy[b]) begin t = a; a = b; b = t; end
		if (vy[a] > vy[c]) begin t = a; a = c; c = t; end
		if (vy[b] > vy[c]) begin t = b; b = c; c = t; end

		if ((vy[a] == vy[b] && vy[a] == vy[c]) || (vx[a] == vx[b] && vx[a] == vx[c])) begin
			reject_count++;
			return;
		end

		if (vy[a] == vy[b]) begin
			if (vx[a] > vx[b]) begin t = a; a = b; b = t; end
			if (vy[a] >= vy[c]) begin
				reject_count++;
				return;
			end
			trapezoids_due.push_back(make_trap(vy[a], vy[c], a, c, b, c, 1'b1));
			flat_count++;
			return;
		end

		if (vy[b] == vy[c]) begin
			if (vx[b] > vx[c]) begin t = b; b = c; c = t; end
			if (vy[a] >= vy[c]) begin
				reject_count++;
				return;
			end
			trapezoids_due.push_back(make_trap(vy[a], vy[c], a, b, a, c, 1'b1));
			flat_count++;
			return;
		end

		// Exact side test; collinear falls to the left side.
		dxab = vx[b] - vx[a];
		dyab = vy[b] - vy[a];
		dxac = vx[c] - vx[a];
		dyac = vy[c] - vy[a];
		cross_ab = dxab * dyac;
		cross_ac = dxac * dyab;
		if (cross_ab <= cross_ac) begin
			trapezoids_due.push_back(make_trap(vy[a], vy[b], a, b, a, c, 1'b0));
			trapezoids_due.push_back(make_trap(vy[b], vy[c], b, c, a, c, 1'b1));
		end else begin
			trapezoids_due.push_back(make_trap(vy[a], vy[b], a, c, a, b, 1'b0));
			trapezoids_due.push_back(make_trap(vy[b], vy[c], a, c, b, c, 1'b1));
		end
		split_count++;
	endfunction

	// Offer one triangle after a random gap, none under src_steady; hold it until taken.
	// Leave valid high on return so a back-to-back request needs no second assignment.
	task automatic send_triangle(input tts_pkg::coord_t x0, input tts_pkg::coord_t y0,
		input tts_pkg::coord_t x1, input tts_pkg::coord_t y1, input tts_pkg::coord_t x2,
		input tts_pkg::coord_t y2);
		int gap;
		gap = src_steady ? 0 : pick_gap();
		if (gap > 0) begin
			triangle_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		triangle_ch.valid    <= 1'b1;
		triangle_ch.x_first  <= x0;
		triangle_ch.y_first  <= y0;
		triangle_ch.x_second <= x1;
		triangle_ch.y_second <= y1;
		triangle_ch.x_third  <= x2;
		triangle_ch.y_third  <= y2;
		do
			@(posedge clk);
		while (!triangle_ch.ready);
		predict_trapezoids(x0, y0, x1, y1, x2, y2);
		triangles_sent++;
	endtask

	// Drop valid, hold the input until all owed trapezoids are out or DRAIN_LIMIT is hit.
	task automatic wait_for_drain();
		int waited;
		waited = 0;
		triangle_ch.valid <= 1'b0;
		@(posedge clk);
		while (trapezoids_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
	endtask

	// Draw one triangle from a mix of shapes: general, small grid, flat, degenerate,
	// collinear and extreme coordinates.
	task automatic pick_triangle(output tts_pkg::coord_t x0, output tts_pkg::coord_t y0,
		output tts_pkg::coord_t x1, output tts_pkg::coord_t y1, output tts_pkg::coord_t x2,
		output tts_pkg::coord_t y2);
		int kind, bx, by, sx, sy, k0, k1, k2;
		tts_pkg::coord_t v[6];
		kind = $urandom_range(0, 99);
		for (int i = 0; i < 6; i++)
			v[i] = tts_pkg::coord_t'($urandom);
		if (kind < 45) begin
			// keep the full-range draw
		end else if (kind < 65) begin
			for (int i = 0; i < 6; i++)
				v[i] = tts_pkg::coord_t'((int'($urandom_range(0, 6)) - 3) * 65536
					+ ($urandom_range(0, 3) == 0 ? int'($urandom_range(0, 65535)) : 0));
		end else if (kind < 80) begin
			case ($urandom_range(0, 2))
				0: v[3] = v[1];
				1: v[5] = v[1];
				default: v[5] = v[3];
			endcase
		end else if (kind < 87) begin
			if ($urandom_range(0, 1) == 0) begin
				v[3] = v[1];
				v[5] = v[1];
			end else begin
				v[2] = v[0];
				v[4] = v[0];
			end
		end else if (kind < 94) begin
			bx = int'($urandom_range(0, 2000)) - 1000;
			by = int'($urandom_range(0, 2000)) - 1000;
			sx = int'($urandom_range(0, 100)) - 50;
			sy = int'($urandom_range(0, 100)) - 50;
			k0 = $urandom_range(0, 2);
			k1 = (k0 + 1 + $urandom_range(0, 1)) % 3;
			k2 = 3 - k0 - k1;
			v[0] = fx(bx + k0 * sx); v[1] = fx(by + k0 * sy);
			v[2] = fx(bx + k1 * sx); v[3] = fx(by + k1 * sy);
			v[4] = fx(bx + k2 * sx); v[5] = fx(by + k2 * sy);
		end else begin
			for (int i = 0; i < 6; i++)
				case ($urandom_range(0, 4))
					0: v[i] = COORD_MIN;
					1: v[i] = COORD_MAX;
					2: v[i] = '0;
					3: v[i] = '1;
					default: ;
				endcase
		end
		x0 = v[0]; y0 = v[1]; x1 = v[2]; y1 = v[3]; x2 = v[4]; y2 = v[5];
	endtask

	// Every shape class, sort order, side decision and coordinate extreme once.
	task automatic test_directed_shapes();
		// all y equal, then all x equal in two orders
		send_triangle(fx(0), fx(5), fx(10), fx(5), fx(20), fx(5));
		send_triangle(fx(7), fx(0), fx(7), fx(10), fx(7), fx(20));
		send_triangle(fx(7), fx(20), fx(7), fx(0), fx(7), fx(10));
		// flat top: swapped by x, already ordered, reached through the y sort
		send_triangle(fx(100), fx(0), fx(0), fx(0), fx(50), fx(100));
		send_triangle(fx(0), fx(0), fx(100), fx(0), fx(50), fx(100));
		send_triangle(fx(50), fx(100), fx(100), fx(0), fx(0), fx(0));
		// equal y on first and third vertex: stable sort must keep their order
		send_triangle(fx(0), fx(0), fx(5), fx(9), fx(9), fx(0));
		// flat bottom: swapped by x, then ordered
		send_triangle(fx(0), fx(0), fx(100), fx(50), fx(-100), fx(50));
		send_triangle(fx(-100), fx(50), fx(0), fx(0), fx(100), fx(50));
		// general: middle vertex left, right, and fully reversed y order
		send_triangle(fx(0), fx(0), fx(-50), fx(40), fx(10), fx(100));
		send_triangle(fx(0), fx(0), fx(80), fx(40), fx(10), fx(100));
		send_triangle(fx(10), fx(100), fx(80), fx(40), fx(0), fx(0));
		// collinear but not degenerate: zero-area split on the left side
		send_triangle(fx(0), fx(0), fx(1), fx(1), fx(2), fx(2));
		send_triangle(fx(0), fx(0), fx(-3), fx(1), fx(-6), fx(2));
		send_triangle(fx(2), fx(2), fx(0), fx(0), fx(1), fx(1));
		// one LSB off the line on either side
		send_triangle(fx(0), fx(0), fx(1) + 1, fx(1), fx(2), fx(2));
		send_triangle(fx(0), fx(0), fx(1) - 1, fx(1), fx(2), fx(2));
		// coordinate extremes, widest differences and products
		send_triangle(COORD_MIN, COORD_MIN, COORD_MAX, '0, '0, COORD_MAX);
		send_triangle(COORD_MAX, COORD_MIN, COORD_MIN, '0, COORD_MAX, COORD_MAX);
		send_triangle(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
		send_triangle(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, '0, COORD_MAX);
		send_triangle(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, '0);
		send_triangle(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
		send_triangle('1, '1, '0, COORD_MAX, COORD_MIN, '0);
	endtask

	// Random mix with idling on both sides; pause the input now and then until drained.
	task automatic test_random_mix(input int count);
		tts_pkg::coord_t x0, y0, x1, y1, x2, y2;
		for (int i = 0; i < count; i++) begin
			pick_triangle(x0, y0, x1, y1, x2, y2);
			send_triangle(x0, y0, x1, y1, x2, y2);
			if (i % 120 == 119)
				wait_for_drain();
		end
	endtask

	// Back-to-back requests with the output always ready: full rate.
	task automatic test_steady_stream(input int count);
		tts_pkg::coord_t x0, y0, x1, y1, x2, y2;
		src_steady  = 1;
		sink_steady = 1;
		for (int i = 0; i < count; i++) begin
			pick_triangle(x0, y0, x1, y1, x2, y2);
			send_triangle(x0, y0, x1, y1, x2, y2);
		end
		src_steady  = 0;
		sink_steady = 0;
	endtask

	// Park the output while requests keep coming, so the queue fills and the
	// input stalls; then release and drain.
	task automatic test_output_stall(input int count);
		src_steady   = 1;
		park_request = PARK_CYCLES;
		for (int i = 0; i < count; i++)
			send_triangle(tts_pkg::coord_t'($urandom), tts_pkg::coord_t'($urandom),
				tts_pkg::coord_t'($urandom), tts_pkg::coord_t'($urandom),
				tts_pkg::coord_t'($urandom), tts_pkg::coord_t'($urandom));
		src_steady = 0;
		wait_for_drain();
	endtask

	// Output side: random stalls, a long park on request, stretches always ready.
	initial begin
		int stall_left;
		int park_left;
		stall_left = 0;
		park_left  = 0;
		trapezoid_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (park_request > 0) begin
				park_left    = park_request;
				park_request = 0;
			end
			if (park_left > 0) begin
				trapezoid_ch.ready <= 1'b0;
				park_left--;
			end else if (stall_left > 0) begin
				trapezoid_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				trapezoid_ch.ready <= 1'b1;
				if (!sink_steady && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	task automatic report_fault(input string what, input tts_pkg::trap_t due,
		input tts_pkg::trap_t seen);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("%s at cycle %0d", what, cycle_count);
			$display("  expected %s", trap_text(due));
			$display("  actual   %s", trap_text(seen));
		end
	endtask

	// Compare each accepted trapezoid, field by field, against the oldest prediction.
	always @(posedge clk) begin
		tts_pkg::trap_t seen;
		tts_pkg::trap_t due;
		if (arst_n && trapezoid_ch.valid && trapezoid_ch.ready) begin
			seen = make_trap(trapezoid_ch.top_y, trapezoid_ch.bottom_y,
				trapezoid_ch.left_from, trapezoid_ch.left_to,
				trapezoid_ch.right_from, trapezoid_ch.right_to, trapezoid_ch.last_piece);
			traps_checked++;
			if (trapezoids_due.size() == 0) begin
				report_fault("trapezoid with none expected", '0, seen);
			end else begin
				due = trapezoids_due.pop_front();
				if (seen.top_y !== due.top_y || seen.bottom_y !== due.bottom_y
					|| seen.left_from !== due.left_from || seen.left_to !== due.left_to
					|| seen.right_from !== due.right_from || seen.right_to !== due.right_to
					|| seen.last_piece !== due.last_piece)
					report_fault("trapezoid mismatch", due, seen);
			end
		end
	end

	initial begin
		// Hold every input at a known value during reset.
		arst_n               <= 1'b0;
		triangle_ch.valid    <= 1'b0;
		triangle_ch.x_first  <= '0;
		triangle_ch.y_first  <= '0;
		triangle_ch.x_second <= '0;
		triangle_ch.y_second <= '0;
		triangle_ch.x_third  <= '0;
		triangle_ch.y_third  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_shapes();
		test_random_mix(480);
		test_steady_stream(60);
		test_output_stall(40);
		test_random_mix(40);

		// Drain, then give a stray late trapezoid time to show up.
		wait_for_drain();
		repeat (4 * PIPE_LATENCY) @(posedge clk);
		if (trapezoids_due.size() != 0) begin
			$display("%0d trapezoids never arrived", trapezoids_due.size());
			mismatches += trapezoids_due.size();
		end

		$display("%0d triangles: %0d split, %0d flat, %0d rejected; %0d trapezoids checked",
			triangles_sent, split_count, flat_count, reject_count, traps_checked);
		$display("output parked %0d cycles once with input still offered; %0d mismatches",
			PARK_CYCLES, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* sim.f */
sv/tts_pkg.sv
sv/tts_channels.sv
sv/tts_front.sv
sv/tts_queue.sv
sv/tts_back.sv
sv/triangle_trapezoid_split.sv
test/testbench.sv
